[sv/pft_pkg.sv]
// ----------------------------------------------------------------------------
// pft_pkg: shared definitions for the packet filter rule table
// Field widths, operation, kind, direction and status codes, and rule types.
// ----------------------------------------------------------------------------
`default_nettype none

package pft_pkg;

    // Field widths of requests and responses
    localparam int OPCODE_W = 2;
    localparam int IFC_W    = 4;
    localparam int KIND_W   = 2;
    localparam int DIR_W    = 2;
    localparam int VALUE_W  = 48;
    localparam int PROTO_W  = 8;
    localparam int IP_W     = 32;
    localparam int PORT_W   = 16;
    localparam int MAC_W    = 48;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 7;

    // Default table depth
    localparam int DEF_MAX_RULES = 64;

    // Operations
    localparam logic [OPCODE_W-1:0] OP_CLASSIFY = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_ADD      = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_REMOVE   = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_UNUSED   = 2'd3;

    // Rule kinds
    localparam logic [KIND_W-1:0] KIND_PORT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_IPV4 = 2'd1;
    localparam logic [KIND_W-1:0] KIND_MAC  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_BAD  = 2'd3;

    // Match directions
    localparam logic [DIR_W-1:0] DIR_SRC  = 2'd0;
    localparam logic [DIR_W-1:0] DIR_DST  = 2'd1;
    localparam logic [DIR_W-1:0] DIR_BOTH = 2'd2;
    localparam logic [DIR_W-1:0] DIR_BAD  = 2'd3;

    // Status codes
    localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_BAD_DIR   = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_BAD_KIND  = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_BAD_PORT  = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd5;

    // Layer four protocols whose ports take part in matching
    localparam logic [PROTO_W-1:0] PROTO_TCP = 8'd6;
    localparam logic [PROTO_W-1:0] PROTO_UDP = 8'd17;

    // One stored rule, packed with the interface in the top bits
    typedef struct packed {
        logic [IFC_W-1:0]   ifc;
        logic [KIND_W-1:0]  kind;
        logic [DIR_W-1:0]   dir;
        logic [VALUE_W-1:0] value;
    } rule_t;

    // One word of the rule memory
    typedef struct packed {
        logic  valid;
        rule_t rule;
    } mem_word_t;

endpackage

`default_nettype wire

[sv/pft_req_if.sv]
// ----------------------------------------------------------------------------
// pft_req_if: request channel of the packet filter rule table
// Valid/ready handshake carrying one operation with its rule and packet fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface pft_req_if
    import pft_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [OPCODE_W-1:0] opcode;
    logic [IFC_W-1:0]   interface_id;
    logic [KIND_W-1:0]  rule_kind;
    logic [DIR_W-1:0]   match_direction;
    logic [VALUE_W-1:0] rule_value;
    logic [PROTO_W-1:0] ip_protocol;
    logic [IP_W-1:0]    src_ip;
    logic [IP_W-1:0]    dst_ip;
    logic [PORT_W-1:0]  src_port;
    logic [PORT_W-1:0]  dst_port;
    logic [MAC_W-1:0]   src_mac;
    logic [MAC_W-1:0]   dst_mac;

    modport source (
        output valid, opcode, interface_id, rule_kind, match_direction, rule_value,
               ip_protocol, src_ip, dst_ip, src_port, dst_port, src_mac, dst_mac,
        input  ready
    );

    modport sink (
        input  valid, opcode, interface_id, rule_kind, match_direction, rule_value,
               ip_protocol, src_ip, dst_ip, src_port, dst_port, src_mac, dst_mac,
        output ready
    );
endinterface

`default_nettype wire

[sv/pft_rsp_if.sv]
// ----------------------------------------------------------------------------
// pft_rsp_if: response channel of the packet filter rule table
// Valid/ready handshake carrying the drop flag, status and rule count.
// ----------------------------------------------------------------------------
`default_nettype none

interface pft_rsp_if
    import pft_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                drop;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  rules_in_use;

    modport source (
        output valid, drop, status, rules_in_use,
        input  ready
    );

    modport sink (
        input  valid, drop, status, rules_in_use,
        output ready
    );
endinterface

`default_nettype wire

[sv/packet_filter_rule_table.sv]
// A bad or unused request, or an add to a full table, goes to the response state without a scan.
// Classify and remove scan the rule memory at one entry per cycle until a decision or the last
// entry; add stops at the lowest free slot. The single read port of the memory sets this rate.
// One request is handled at a time; a finished response waits in the output register.
// Reset: asynchronous, active low; afterwards a clearing pass marks every memory word invalid,
// during which no request is taken.
// ----------------------------------------------------------------------------
// packet_filter_rule_table: table of drop rules for an ingress packet filter
// Adds, removes and classifies against rules held in a single-port-read memory,
// using one shared matcher stepped over the entries by a small sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module packet_filter_rule_table
    import pft_pkg::*;
#(
    parameter int MAX_RULES = DEF_MAX_RULES
) (
    input  logic       clk,
    input  logic       rst_n,
    pft_req_if.sink    req,
    pft_rsp_if.source  rsp
);

    // Address and counter widths follow from the table depth. The scan index
    // carries one extra bit so that it can hold MAX_RULES itself.
    localparam int ADDR_W = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
    localparam int IDX_W  = ADDR_W + 1;
    localparam int CNT_W  = $clog2(MAX_RULES + 1);

    // Sequencer states
    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;
    localparam logic [1:0] S_RESP  = 2'd3;

    // Compares a rule value against the source and destination operands as
    // the rule's direction asks.
    function automatic logic side_hit(
        input logic [DIR_W-1:0]   dir,
        input logic [VALUE_W-1:0] v,
        input logic [VALUE_W-1:0] s,
        input logic [VALUE_W-1:0] d
    );
        logic h;
        case (dir)
            DIR_SRC:  h = (v == s);
            DIR_DST:  h = (v == d);
            DIR_BOTH: h = (v == s) || (v == d);
            default:  h = 1'b0;
        endcase
        return h;
    endfunction

    // Checks a rule before it is added or removed; the order of the tests
    // decides which error is reported when several apply.
    function automatic logic [STATUS_W-1:0] check_rule(
        input logic [KIND_W-1:0]  kind,
        input logic [DIR_W-1:0]   dir,
        input logic [VALUE_W-1:0] val
    );
        logic [STATUS_W-1:0] st;
        if (dir == DIR_BAD)
            st = STAT_BAD_DIR;
        else if (kind == KIND_BAD)
            st = STAT_BAD_KIND;
        else if (kind == KIND_PORT &&
                 (val[VALUE_W-1:PORT_W] != '0 || val[PORT_W-1:0] == '0))
            st = STAT_BAD_PORT;
        else
            st = STAT_OK;
        return st;
    endfunction

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    logic [1:0]          state_reg,      state_next;
    logic [IDX_W-1:0]    issue_reg,      issue_next;
    logic                pend_reg,       pend_next;
    logic [ADDR_W-1:0]   chk_addr_reg,   chk_addr_next;
    logic [CNT_W-1:0]    count_reg,      count_next;
    logic                res_drop_reg,   res_drop_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic                out_valid_reg,  out_valid_next;

    // Output payload registers
    logic                out_drop_reg,   out_drop_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [COUNT_W-1:0]  out_count_reg,  out_count_next;

    // Request payload held for the length of the scan
    logic [OPCODE_W-1:0] op_reg;
    rule_t               want_reg;
    logic [IP_W-1:0]     sip_reg, dip_reg;
    logic [PORT_W-1:0]   sp_reg,  dp_reg;
    logic [MAC_W-1:0]    smac_reg, dmac_reg;

    // Rule memory with its registered read word
    mem_word_t           rule_mem [MAX_RULES];
    mem_word_t           rd_word_reg;

    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    mem_word_t           mem_wdata;
    logic                mem_re;

    logic                accept;
    logic                issuing;
    logic                found;
    logic [STATUS_W-1:0] req_check;
    rule_t               req_rule;
    logic [VALUE_W-1:0]  s_val, d_val;
    logic                class_hit;
    logic                load_out;
    logic [CNT_W+COUNT_W-1:0] count_ext;

    assign accept  = req.valid && req.ready;
    assign issuing = (issue_reg != IDX_W'(MAX_RULES));

    // The rule as it would be stored; an IPv4 rule keeps only its low 32 bits.
    always_comb
    begin
        req_rule.ifc   = req.interface_id;
        req_rule.kind  = req.rule_kind;
        req_rule.dir   = req.match_direction;
        req_rule.value = req.rule_value;
        if (req.rule_kind == KIND_IPV4)
            req_rule.value[VALUE_W-1:IP_W] = '0;
    end

    assign req_check = check_rule(req.rule_kind, req.match_direction, req.rule_value);

    // ------------------------------------------------------------------
    // Shared matcher: one compare unit, fed each cycle with the word that
    // the memory returned for the previous scan address.
    // ------------------------------------------------------------------
    always_comb
    begin
        case (rd_word_reg.rule.kind)
            KIND_PORT:
            begin
                s_val = VALUE_W'(sp_reg);
                d_val = VALUE_W'(dp_reg);
            end
            KIND_IPV4:
            begin
                s_val = VALUE_W'(sip_reg);
                d_val = VALUE_W'(dip_reg);
            end
            KIND_MAC:
            begin
                s_val = smac_reg;
                d_val = dmac_reg;
            end
            default:
            begin
                s_val = '0;
                d_val = '0;
            end
        endcase
    end

    assign class_hit = rd_word_reg.valid &&
                       (rd_word_reg.rule.ifc == want_reg.ifc) &&
                       (rd_word_reg.rule.kind != KIND_BAD) &&
                       side_hit(rd_word_reg.rule.dir, rd_word_reg.rule.value, s_val, d_val);

    // What ends the scan depends on the operation: a matching rule for a
    // classify, an equal valid rule for a remove, a free slot for an add.
    always_comb
    begin
        case (op_reg)
            OP_CLASSIFY: found = class_hit;
            OP_ADD:      found = !rd_word_reg.valid;
            OP_REMOVE:   found = rd_word_reg.valid && (rd_word_reg.rule == want_reg);
            default:     found = 1'b0;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        issue_next      = issue_reg;
        pend_next       = pend_reg;
        chk_addr_next   = chk_addr_reg;
        count_next      = count_reg;
        res_drop_next   = res_drop_reg;
        res_status_next = res_status_reg;
        mem_we          = 1'b0;
        mem_waddr       = chk_addr_reg;
        mem_wdata       = '0;
        mem_re          = 1'b0;
        load_out        = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                // One word per cycle is marked invalid after reset.
                mem_we     = 1'b1;
                mem_waddr  = issue_reg[ADDR_W-1:0];
                mem_wdata  = '0;
                issue_next = issue_reg + IDX_W'(1);
                if (issue_reg[ADDR_W-1:0] == ADDR_W'(MAX_RULES - 1))
                    state_next = S_IDLE;
            end

            S_IDLE:
            begin
                if (accept)
                begin
                    issue_next      = '0;
                    pend_next       = 1'b0;
                    res_drop_next   = 1'b0;
                    res_status_next = STAT_OK;
                    case (req.opcode)
                        OP_CLASSIFY:
                            state_next = S_SCAN;
                        OP_ADD:
                        begin
                            if (count_reg >= CNT_W'(MAX_RULES))
                            begin
                                res_status_next = STAT_FULL;
                                state_next      = S_RESP;
                            end
                            else if (req_check != STAT_OK)
                            begin
                                res_status_next = req_check;
                                state_next      = S_RESP;
                            end
                            else
                                state_next = S_SCAN;
                        end
                        OP_REMOVE:
                        begin
                            if (req_check != STAT_OK)
                            begin
                                res_status_next = req_check;
                                state_next      = S_RESP;
                            end
                            else
                                state_next = S_SCAN;
                        end
                        default:
                            state_next = S_RESP;
                    endcase
                end
            end

            S_SCAN:
            begin
                if (pend_reg && found)
                begin
                    // The entry under test decides the request.
                    state_next = S_RESP;
                    case (op_reg)
                        OP_CLASSIFY:
                            res_drop_next = 1'b1;
                        OP_ADD:
                        begin
                            mem_we           = 1'b1;
                            mem_wdata.valid  = 1'b1;
                            mem_wdata.rule   = want_reg;
                            count_next       = count_reg + CNT_W'(1);
                        end
                        OP_REMOVE:
                        begin
                            mem_we           = 1'b1;
                            mem_wdata.valid  = 1'b0;
                            mem_wdata.rule   = rd_word_reg.rule;
                            if (count_reg != '0)
                                count_next = count_reg - CNT_W'(1);
                        end
                        default:
                            res_drop_next = 1'b0;
                    endcase
                end
                else if (!issuing && !pend_reg)
                begin
                    // Every entry has been seen without a decision.
                    state_next = S_RESP;
                    if (op_reg == OP_REMOVE)
                        res_status_next = STAT_NOT_FOUND;
                end
                else
                begin
                    mem_re        = issuing;
                    pend_next     = issuing;
                    chk_addr_next = issue_reg[ADDR_W-1:0];
                    if (issuing)
                        issue_next = issue_reg + IDX_W'(1);
                end
            end

            S_RESP:
            begin
                // Hand the result to the output register once it is free.
                if (!out_valid_reg || rsp.ready)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    assign count_ext = {{COUNT_W{1'b0}}, count_reg};

    // Output register: loads a finished result, empties when taken.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_drop_next   = out_drop_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        if (load_out)
        begin
            out_valid_next  = 1'b1;
            out_drop_next   = res_drop_reg;
            out_status_next = res_status_reg;
            out_count_next  = count_ext[COUNT_W-1:0];
        end
        else if (rsp.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            issue_reg      <= '0;
            pend_reg       <= 1'b0;
            chk_addr_reg   <= '0;
            count_reg      <= '0;
            res_drop_reg   <= 1'b0;
            res_status_reg <= STAT_OK;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            issue_reg      <= issue_next;
            pend_reg       <= pend_next;
            chk_addr_reg   <= chk_addr_next;
            count_reg      <= count_next;
            res_drop_reg   <= res_drop_next;
            res_status_reg <= res_status_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        out_drop_reg   <= out_drop_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
        if (accept)
        begin
            op_reg   <= req.opcode;
            want_reg <= req_rule;
            sip_reg  <= req.src_ip;
            dip_reg  <= req.dst_ip;
            smac_reg <= req.src_mac;
            dmac_reg <= req.dst_mac;
            // Ports only count for TCP and UDP; otherwise they read as zero,
            // which no port rule can match.
            if (req.ip_protocol == PROTO_TCP || req.ip_protocol == PROTO_UDP)
            begin
                sp_reg <= req.src_port;
                dp_reg <= req.dst_port;
            end
            else
            begin
                sp_reg <= '0;
                dp_reg <= '0;
            end
        end
    end

    // Rule memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            rule_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_word_reg <= rule_mem[issue_reg[ADDR_W-1:0]];
    end

    assign req.ready        = (state_reg == S_IDLE);
    assign rsp.valid        = out_valid_reg;
    assign rsp.drop         = out_drop_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.rules_in_use = out_count_reg;

endmodule

`default_nettype wire
